>>> sv/gtg_pkg.sv
// Package: shared constants, types and arctangent table for the go-to-goal steering unit.
package gtg_pkg;

  localparam int unsigned FractionBits = 11;
  localparam int unsigned CordicSteps  = 30;
  localparam int unsigned DiffW        = 17;
  localparam int unsigned CordW        = 36;
  localparam int unsigned AngW         = 34;
  localparam int unsigned SumW         = 33;
  localparam int unsigned RootW        = 17;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 16;

  localparam logic signed [AngW-1:0] PiQ30 = 34'sd3373259426;

  typedef enum logic [CfgIdxW-1:0] {
    RegTargetX       = 3'd0,
    RegTargetY       = 3'd1,
    RegTargetHeading = 3'd2,
    RegDistTol       = 3'd3,
    RegAngleTol      = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic                     moving;
    logic signed [16:0]       head_err;
    logic signed [15:0]       heading;
  } side_t;

  function automatic logic signed [AngW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [AngW-1:0] v;
    begin
      case (idx)
        5'd0:    v = 34'sd843314856;
        5'd1:    v = 34'sd497837829;
        5'd2:    v = 34'sd263043836;
        5'd3:    v = 34'sd133525158;
        5'd4:    v = 34'sd67021686;
        5'd5:    v = 34'sd33543515;
        5'd6:    v = 34'sd16775850;
        5'd7:    v = 34'sd8388437;
        5'd8:    v = 34'sd4194282;
        5'd9:    v = 34'sd2097149;
        5'd10:   v = 34'sd1048575;
        5'd11:   v = 34'sd524287;
        5'd12:   v = 34'sd262143;
        5'd13:   v = 34'sd131071;
        5'd14:   v = 34'sd65535;
        5'd15:   v = 34'sd32767;
        5'd16:   v = 34'sd16383;
        5'd17:   v = 34'sd8191;
        5'd18:   v = 34'sd4095;
        5'd19:   v = 34'sd2047;
        5'd20:   v = 34'sd1023;
        5'd21:   v = 34'sd511;
        5'd22:   v = 34'sd255;
        5'd23:   v = 34'sd127;
        5'd24:   v = 34'sd63;
        5'd25:   v = 34'sd31;
        5'd26:   v = 34'sd15;
        5'd27:   v = 34'sd7;
        5'd28:   v = 34'sd3;
        5'd29:   v = 34'sd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [16:0] sat17(input logic signed [AngW:0] v);
    begin
      if (v > 35'sd65535) begin
        return 17'sd65535;
      end else if (v < -35'sd65536) begin
        return -17'sd65536;
      end else begin
        return v[16:0];
      end
    end
  endfunction

endpackage

>>> sv/gtg_isqrt.sv
// Pipelined square root, one result bit per stage, with a side payload carried alongside.
module gtg_isqrt #(
  parameter int unsigned SideW = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         valid_i,
  input  logic [gtg_pkg::SumW-1:0]     rad_i,
  input  logic [SideW-1:0]             side_i,
  output logic                         valid_o,
  output logic [gtg_pkg::RootW-1:0]    root_o,
  output logic [SideW-1:0]             side_o
);

  localparam int unsigned N  = gtg_pkg::RootW;
  localparam int unsigned RW = gtg_pkg::SumW + 1;

  logic [N:0]                    vld_q;
  logic [RW-1:0]                 rem_q  [N+1];
  logic [RW-1:0]                 rad_q  [N+1];
  logic [N-1:0]                  root_q [N+1];
  logic [SideW-1:0]              side_q [N+1];

  assign rem_q[0]  = '0;
  assign rad_q[0]  = {1'b0, rad_i};
  assign root_q[0] = '0;
  assign side_q[0] = side_i;

  assign vld_q[0] = valid_i;

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [RW-1:0] rem_d;
    logic [RW-1:0] trial;
    logic [N-1:0]  root_d;
    logic [RW-1:0] rem_r;
    logic [RW-1:0] rad_r;
    logic [N-1:0]  root_r;
    logic [SideW-1:0] side_r;
    logic          vld_r;

    always_comb begin
      rem_d  = {rem_q[s][RW-3:0], rad_q[s][RW-1 -: 2]};
      trial  = {root_q[s], 2'b01};
      root_d = {root_q[s][N-2:0], 1'b0};
      if (rem_d >= trial) begin
        rem_d  = rem_d - trial;
        root_d = {root_q[s][N-2:0], 1'b1};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_r <= 1'b0;
      end else if (adv_i) begin
        vld_r <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_r  <= rem_d;
        rad_r  <= {rad_q[s][RW-3:0], 2'b00};
        root_r <= root_d;
        side_r <= side_q[s];
      end
    end

    assign vld_q[s+1]  = vld_r;
    assign rem_q[s+1]  = rem_r;
    assign rad_q[s+1]  = rad_r;
    assign root_q[s+1] = root_r;
    assign side_q[s+1] = side_r;
  end

  assign valid_o = vld_q[N];
  assign root_o  = root_q[N];
  assign side_o  = side_q[N];

endmodule

>>> sv/gtg_cordic.sv
// Pipelined CORDIC vectoring unit giving atan2 in Q30, one rotation per stage.
module gtg_cordic (
  input  logic                              clk_i,
  input  logic                              adv_i,
  input  logic signed [gtg_pkg::DiffW-1:0]  dx_i,
  input  logic signed [gtg_pkg::DiffW-1:0]  dy_i,
  output logic signed [gtg_pkg::AngW-1:0]   ang_o
);

  localparam int unsigned N  = gtg_pkg::CordicSteps;
  localparam int unsigned CW = gtg_pkg::CordW;
  localparam int unsigned AW = gtg_pkg::AngW;

  logic signed [CW-1:0] x_q [N+1];
  logic signed [CW-1:0] y_q [N+1];
  logic signed [AW-1:0] z_q [N+1];
  logic                 zero_q [N+1];

  logic signed [CW-1:0] x0;
  logic signed [CW-1:0] y0;
  logic signed [AW-1:0] z0;

  always_comb begin
    x0 = {{(CW-gtg_pkg::DiffW-16){dx_i[gtg_pkg::DiffW-1]}}, dx_i, 16'd0};
    y0 = {{(CW-gtg_pkg::DiffW-16){dy_i[gtg_pkg::DiffW-1]}}, dy_i, 16'd0};
    z0 = '0;
    if (dx_i < 0) begin
      z0 = (dy_i >= 0) ? gtg_pkg::PiQ30 : -gtg_pkg::PiQ30;
      x0 = -x0;
      y0 = -y0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q[0]    <= x0;
      y_q[0]    <= y0;
      z_q[0]    <= z0;
      zero_q[0] <= (dx_i == '0) && (dy_i == '0);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + gtg_pkg::atan_q30(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - gtg_pkg::atan_q30(5'(i));
        end
      end
    end
  end

  assign ang_o = zero_q[N] ? '0 : z_q[N];

endmodule

>>> sv/go_to_goal_steering_unit.sv
// Top level: go-to-goal steering unit, pose in, drive command out.
// One pose is taken per cycle unless a waiting result is stalled; each travels
// a pipeline of 33 register stages (offset and squares, a 17-stage square-root
// pipeline running alongside a 30-step CORDIC atan2, then the dead band and
// output register). A stall on the output freezes the whole pipeline, so a
// waiting result also stalls the input.
module go_to_goal_steering_unit #(
  parameter int unsigned FRACTION_BITS = gtg_pkg::FractionBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [15:0]                  pose_x_i,
  input  logic signed [15:0]                  pose_y_i,
  input  logic signed [15:0]                  pose_heading_i,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [15:0]                         linear_speed_o,
  output logic signed [16:0]                  angular_speed_o,
  output logic                                arrived_o,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gtg_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [gtg_pkg::CfgDataW-1:0]        cfg_data_i
);

  localparam int unsigned SqrtLat = gtg_pkg::RootW;
  localparam int unsigned CordLat = gtg_pkg::CordicSteps;
  localparam int unsigned PadLat  = CordLat - SqrtLat;
  localparam int unsigned Shift   = 30 - FRACTION_BITS;
  localparam int unsigned SideW   = $bits(gtg_pkg::side_t);

  logic signed [15:0] tx_q, ty_q, th_q;
  logic [14:0]        dtol_q, atol_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q   <= '0;
      ty_q   <= '0;
      th_q   <= '0;
      dtol_q <= 15'd205;
      atol_q <= 15'd205;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_i)
        gtg_pkg::RegTargetX:       tx_q   <= cfg_data_i;
        gtg_pkg::RegTargetY:       ty_q   <= cfg_data_i;
        gtg_pkg::RegTargetHeading: th_q   <= cfg_data_i;
        gtg_pkg::RegDistTol:       dtol_q <= cfg_data_i[14:0];
        gtg_pkg::RegAngleTol:      atol_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_q;
  assign adv       = !out_valid_q || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_q;

  // Stage 0: offsets
  logic                                   s0_vld_q;
  logic signed [gtg_pkg::DiffW-1:0]       dx_q, dy_q;
  logic signed [15:0]                     ph0_q;
  logic signed [16:0]                     herr0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= in_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q    <= 17'(tx_q) - 17'(pose_x_i);
      dy_q    <= 17'(ty_q) - 17'(pose_y_i);
      ph0_q   <= pose_heading_i;
      herr0_q <= 17'(th_q) - 17'(pose_heading_i);
    end
  end

  // Stage 1: squares and distance test
  logic                          s1_vld_q;
  logic [gtg_pkg::SumW-1:0]      sum_q;
  gtg_pkg::side_t                side1_q;
  logic [33:0]                   sq_x, sq_y;

  assign sq_x = 34'(dx_q * dx_q);
  assign sq_y = 34'(dy_q * dy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= s0_vld_q;
    end
  end

  logic [gtg_pkg::SumW-1:0] sum_d;
  assign sum_d = sq_x[gtg_pkg::SumW-1:0] + sq_y[gtg_pkg::SumW-1:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q            <= sum_d;
      side1_q.moving   <= sum_d > {3'd0, 30'(dtol_q * dtol_q)};
      side1_q.head_err <= herr0_q;
      side1_q.heading  <= ph0_q;
    end
  end

  logic signed [gtg_pkg::AngW-1:0] ang;

  gtg_cordic u_cordic (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .dx_i   (dx_q),
    .dy_i   (dy_q),
    .ang_o  (ang)
  );

  logic                      sq_vld;
  logic [gtg_pkg::RootW-1:0] root;
  logic [SideW-1:0]          sq_side;

  gtg_isqrt #(.SideW(SideW)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s1_vld_q),
    .rad_i   (sum_q),
    .side_i  (side1_q),
    .valid_o (sq_vld),
    .root_o  (root),
    .side_o  (sq_side)
  );

  logic                      pad_vld_q  [PadLat+1];
  logic [gtg_pkg::RootW-1:0] pad_root_q [PadLat+1];
  logic [SideW-1:0]          pad_side_q [PadLat+1];

  assign pad_vld_q[0]  = sq_vld;
  assign pad_root_q[0] = root;
  assign pad_side_q[0] = sq_side;

  for (genvar p = 0; p < PadLat; p++) begin : g_pad
    logic                      v_r;
    logic [gtg_pkg::RootW-1:0] r_r;
    logic [SideW-1:0]          s_r;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_r <= 1'b0;
      end else if (adv) begin
        v_r <= pad_vld_q[p];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        r_r <= pad_root_q[p];
        s_r <= pad_side_q[p];
      end
    end
    assign pad_vld_q[p+1]  = v_r;
    assign pad_root_q[p+1] = r_r;
    assign pad_side_q[p+1] = s_r;
  end

  gtg_pkg::side_t fin_side;
  assign fin_side = gtg_pkg::side_t'(pad_side_q[PadLat]);

  logic signed [gtg_pkg::AngW-1:0] ang_rnd;
  logic signed [gtg_pkg::AngW:0]   err_w;
  logic signed [16:0]              err_sat;
  logic [16:0]                     err_mag;
  logic signed [16:0]              ang_d;

  always_comb begin
    ang_rnd = (ang + (gtg_pkg::AngW'(1) <<< (Shift - 1))) >>> Shift;
    err_w   = (gtg_pkg::AngW+1)'(ang_rnd) - (gtg_pkg::AngW+1)'(fin_side.heading);
    err_sat = gtg_pkg::sat17(err_w);
    err_mag = err_sat[16] ? 17'(-err_sat) : 17'(err_sat);
    if (fin_side.moving) begin
      ang_d = (err_mag < {2'b00, atol_q}) ? '0 : err_sat;
    end else begin
      ang_d = fin_side.head_err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= pad_vld_q[PadLat];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      linear_speed_o  <= fin_side.moving ? 16'(pad_root_q[PadLat] >> 1) : '0;
      angular_speed_o <= ang_d;
      arrived_o       <= !fin_side.moving;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && arrived_o |-> linear_speed_o == '0)
    else $error("arrived with nonzero speed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(angular_speed_o))
    else $error("result changed while stalled");

endmodule
